FILE: hdl/sha256_pkg.sv
`default_nettype none

package sha256_pkg;

    // input beat: one optional message byte and an end marker
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } in_beat_t;

    // output beat: one digest word
    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } out_beat_t;

    // byte source select for the block shift register
    localparam logic [1:0] SRC_INPUT = 2'd0;
    localparam logic [1:0] SRC_MARK  = 2'd1;
    localparam logic [1:0] SRC_ZERO  = 2'd2;
    localparam logic [1:0] SRC_LEN   = 2'd3;

    // controller to datapath commands
    typedef struct packed {
        logic       put_byte;
        logic [1:0] byte_src;
        logic [2:0] len_idx;
        logic       add_bits;
        logic       init_work;
        logic       round_en;
        logic [5:0] round_idx;
        logic       fold;
        logic       out_shift;
        logic       reinit;
    } dp_cmd_t;

    localparam logic [5:0]  FILL_LAST     = 6'd63;
    localparam logic [5:0]  LEN_START     = 6'd56;
    localparam logic [5:0]  ROUND_LAST    = 6'd63;
    localparam logic [2:0]  WORD_LAST     = 3'd7;
    localparam logic [7:0]  PAD_MARK      = 8'h80;
    localparam logic [63:0] BITS_PER_BYTE = 64'd8;

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

`default_nettype wire

FILE: hdl/sha256_datapath.sv
`default_nettype none

module sha256_datapath (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire sha256_pkg::dp_cmd_t cmd,
    input  wire logic [7:0]          data_byte,
    output logic [31:0]              digest_word
);
    import sha256_pkg::*;

    // block bytes, later the rolling schedule window; word 0 sits at the top
    logic [511:0] blk_reg;
    logic [511:0] blk_next;
    logic [31:0]  work_reg [8];
    logic [31:0]  work_next [8];
    logic [31:0]  hash_reg [8];
    logic [31:0]  hash_next [8];
    logic [63:0]  bit_total_reg;
    logic [63:0]  bit_total_next;

    logic [7:0]  len_byte;
    logic [7:0]  put_value;
    logic [31:0] w_cur;
    logic [31:0] w_new;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] ch;
    logic [31:0] maj;

    // length byte, most significant first
    assign len_byte = bit_total_reg[{~cmd.len_idx, 3'b000} +: 8];

    // byte source mux
    always_comb
    begin
        case (cmd.byte_src)
            SRC_INPUT: put_value = data_byte;
            SRC_MARK:  put_value = PAD_MARK;
            SRC_ZERO:  put_value = 8'd0;
            SRC_LEN:   put_value = len_byte;
            default:   put_value = 8'd0;
        endcase
    end

    // schedule expansion from the window taps
    assign w_cur = blk_reg[511:480];
    assign w_new = small_sigma1(blk_reg[511 - 32*14 -: 32]) + blk_reg[511 - 32*9 -: 32]
                 + small_sigma0(blk_reg[511 - 32*1 -: 32]) + w_cur;

    // one compression round
    assign ch  = (work_reg[4] & work_reg[5]) ^ (~work_reg[4] & work_reg[6]);
    assign maj = (work_reg[0] & work_reg[1]) ^ (work_reg[0] & work_reg[2])
               ^ (work_reg[1] & work_reg[2]);
    assign t1  = work_reg[7] + big_sigma1(work_reg[4]) + ch + ROUND_K[cmd.round_idx] + w_cur;
    assign t2  = big_sigma0(work_reg[0]) + maj;

    // block register and working variables
    always_comb
    begin
        blk_next = blk_reg;
        if (cmd.put_byte)
        begin
            blk_next = {blk_reg[503:0], put_value};
        end
        else if (cmd.round_en)
        begin
            blk_next = {blk_reg[479:0], w_new};
        end

        for (int j = 0; j < 8; j++)
        begin
            work_next[j] = work_reg[j];
        end
        if (cmd.init_work)
        begin
            for (int j = 0; j < 8; j++)
            begin
                work_next[j] = hash_reg[j];
            end
        end
        else if (cmd.round_en)
        begin
            work_next[0] = t1 + t2;
            work_next[1] = work_reg[0];
            work_next[2] = work_reg[1];
            work_next[3] = work_reg[2];
            work_next[4] = work_reg[3] + t1;
            work_next[5] = work_reg[4];
            work_next[6] = work_reg[5];
            work_next[7] = work_reg[6];
        end
    end

    // chaining value and bit count
    always_comb
    begin
        for (int j = 0; j < 8; j++)
        begin
            hash_next[j] = hash_reg[j];
        end
        if (cmd.reinit)
        begin
            for (int j = 0; j < 8; j++)
            begin
                hash_next[j] = INIT_HASH[j];
            end
        end
        else if (cmd.fold)
        begin
            for (int j = 0; j < 8; j++)
            begin
                hash_next[j] = hash_reg[j] + work_reg[j];
            end
        end
        else if (cmd.out_shift)
        begin
            for (int j = 0; j < 7; j++)
            begin
                hash_next[j] = hash_reg[j + 1];
            end
            hash_next[7] = hash_reg[0];
        end

        bit_total_next = bit_total_reg;
        if (cmd.reinit)
        begin
            bit_total_next = 64'd0;
        end
        else if (cmd.add_bits)
        begin
            bit_total_next = bit_total_reg + BITS_PER_BYTE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < 8; j++)
            begin
                hash_reg[j] <= INIT_HASH[j];
            end
            bit_total_reg <= 64'd0;
        end
        else
        begin
            for (int j = 0; j < 8; j++)
            begin
                hash_reg[j] <= hash_next[j];
            end
            bit_total_reg <= bit_total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg <= blk_next;
        for (int j = 0; j < 8; j++)
        begin
            work_reg[j] <= work_next[j];
        end
    end

    // words leave from the front of the rotating hash
    assign digest_word = hash_reg[0];

endmodule

`default_nettype wire

FILE: hdl/sha256_ctrl.sv
`default_nettype none

module sha256_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic                byte_present,
    input  wire logic                end_of_message,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [2:0]               word_index,
    output logic                     last_word,
    output sha256_pkg::dp_cmd_t      cmd
);
    import sha256_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PAD   = 3'd1;
    localparam logic [2:0] ST_LOAD  = 3'd2;
    localparam logic [2:0] ST_ROUND = 3'd3;
    localparam logic [2:0] ST_FOLD  = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic [5:0] fill_reg;
    logic [5:0] fill_next;
    logic [5:0] round_reg;
    logic [5:0] round_next;
    logic [2:0] word_reg;
    logic [2:0] word_next;
    logic       pad_active_reg;
    logic       pad_active_next;
    logic       pad_first_reg;
    logic       pad_first_next;
    logic       len_phase_reg;
    logic       len_phase_next;

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        round_next      = round_reg;
        word_next       = word_reg;
        pad_active_next = pad_active_reg;
        pad_first_next  = pad_first_reg;
        len_phase_next  = len_phase_reg;
        cmd             = '0;
        cmd.round_idx   = round_reg;
        cmd.len_idx     = fill_reg[2:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (byte_present)
                    begin
                        cmd.put_byte = 1'b1;
                        cmd.byte_src = SRC_INPUT;
                        cmd.add_bits = 1'b1;
                        fill_next    = fill_reg + 6'd1;
                    end
                    if (end_of_message)
                    begin
                        pad_active_next = 1'b1;
                        pad_first_next  = 1'b1;
                    end
                    if (byte_present && fill_reg == FILL_LAST)
                    begin
                        state_next = ST_LOAD;
                    end
                    else if (end_of_message)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                cmd.put_byte = 1'b1;
                if (pad_first_reg)
                begin
                    cmd.byte_src = SRC_MARK;
                end
                else if (len_phase_reg || fill_reg == LEN_START)
                begin
                    cmd.byte_src = SRC_LEN;
                end
                else
                begin
                    cmd.byte_src = SRC_ZERO;
                end
                pad_first_next = 1'b0;
                if (!pad_first_reg && fill_reg == LEN_START)
                begin
                    len_phase_next = 1'b1;
                end
                fill_next = fill_reg + 6'd1;
                if (fill_reg == FILL_LAST)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                cmd.init_work = 1'b1;
                round_next    = 6'd0;
                state_next    = ST_ROUND;
            end
            ST_ROUND:
            begin
                cmd.round_en = 1'b1;
                round_next   = round_reg + 6'd1;
                if (round_reg == ROUND_LAST)
                begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                cmd.fold = 1'b1;
                if (len_phase_reg)
                begin
                    word_next  = 3'd0;
                    state_next = ST_OUT;
                end
                else if (pad_active_reg)
                begin
                    state_next = ST_PAD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    cmd.out_shift = 1'b1;
                    word_next     = word_reg + 3'd1;
                    if (word_reg == WORD_LAST)
                    begin
                        cmd.reinit      = 1'b1;
                        pad_active_next = 1'b0;
                        len_phase_next  = 1'b0;
                        state_next      = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            fill_reg       <= 6'd0;
            round_reg      <= 6'd0;
            word_reg       <= 3'd0;
            pad_active_reg <= 1'b0;
            pad_first_reg  <= 1'b0;
            len_phase_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            round_reg      <= round_next;
            word_reg       <= word_next;
            pad_active_reg <= pad_active_next;
            pad_first_reg  <= pad_first_next;
            len_phase_reg  <= len_phase_next;
        end
    end

    // handshake and output status
    assign in_ready   = (state_reg == ST_IDLE);
    assign out_valid  = (state_reg == ST_OUT);
    assign word_index = word_reg;
    assign last_word  = (word_reg == WORD_LAST);

endmodule

`default_nettype wire

FILE: hdl/sha256_byte_stream_hasher.sv
// Bytes are taken one per cycle; the 64th byte of a block stalls input through the
// working-variable load, 64 rounds of the single round unit and the chaining fold.
// End of message: padding goes in one byte per cycle up to the block end (one or two
// more compressions), then eight digest beats, one per accepted output cycle.
// Reset (async, active low) loads the initial hash, clears the byte and bit counts and
// leaves the block ready for input with no output pending.
`default_nettype none

module sha256_byte_stream_hasher (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire sha256_pkg::in_beat_t  in_data,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output sha256_pkg::out_beat_t      out_data
);
    import sha256_pkg::*;

    dp_cmd_t     cmd;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    sha256_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .byte_present   (in_data.byte_present),
        .end_of_message (in_data.end_of_message),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .word_index     (word_index),
        .last_word      (last_word),
        .cmd            (cmd)
    );

    sha256_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .data_byte   (in_data.data_byte),
        .digest_word (digest_word)
    );

    // output beat
    assign out_data = '{digest_word: digest_word, word_index: word_index,
                        last_word: last_word};

    // input and output never open together
    assert property (@(posedge clk) disable iff (!rst_n) !(in_ready && out_valid))
        else $error("input and output handshakes open together");

    // digest words leave in order without gaps
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_data.last_word |=>
            out_valid && out_data.word_index == 3'($past(out_data.word_index) + 3'd1))
        else $error("digest word order broken");

    // after the last word the block is ready for the next message
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_data.last_word |=> in_ready && !out_valid)
        else $error("block not idle after final digest word");

endmodule

`default_nettype wire

FILE: test/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sha256_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 5;
    localparam int STALL_LIMIT   = 4000;
    localparam int DRAIN_CYCLES  = 300;
    localparam int HOLD_CYCLES   = 400;
    localparam int MAX_REPORTS   = 100;
    localparam int RANDOM_ITEMS  = 410;
    localparam int BLOCK_BYTES   = 64;
    localparam int LENGTH_OFFSET = 56;
    localparam logic [7:0] PAD_BYTE = 8'h80;

    // sha-256 round constants
    localparam logic [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // initial chaining value
    localparam logic [31:0] SHA_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // running hash of the byte stream and the digest words still owed
    class digest_tracker;
        logic [31:0] chain [8];
        logic [7:0]  block_buf [BLOCK_BYTES];
        int          fill;
        logic [63:0] msg_bits;
        out_beat_t   expected_words [$];
        int          errors = 0;
        int          words_checked = 0;
        int          messages = 0;

        function void restart();
            foreach (chain[i]) chain[i] = SHA_IV[i];
            fill = 0;
            msg_bits = '0;
        endfunction

        function logic [31:0] rotate_right(logic [31:0] x, int n);
            return (x >> n) | (x << (32 - n));
        endfunction

        // one 64-round compression of the gathered block
        function void compress();
            logic [31:0] w [64];
            logic [31:0] a, b, c, d, e, f, g, h;
            logic [31:0] t1, t2, lo, hi;
            for (int i = 0; i < 16; i++)
                w[i] = {block_buf[4*i], block_buf[4*i+1], block_buf[4*i+2], block_buf[4*i+3]};
            for (int i = 16; i < 64; i++)
            begin
                lo = rotate_right(w[i-15], 7) ^ rotate_right(w[i-15], 18) ^ (w[i-15] >> 3);
                hi = rotate_right(w[i-2], 17) ^ rotate_right(w[i-2], 19) ^ (w[i-2] >> 10);
                w[i] = w[i-16] + lo + w[i-7] + hi;
            end
            a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
            e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
            for (int i = 0; i < 64; i++)
            begin
                t1 = h + (rotate_right(e, 6) ^ rotate_right(e, 11) ^ rotate_right(e, 25))
                     + ((e & f) ^ (~e & g)) + SHA_K[i] + w[i];
                t2 = (rotate_right(a, 2) ^ rotate_right(a, 13) ^ rotate_right(a, 22))
                     + ((a & b) ^ (a & c) ^ (b & c));
                h = g; g = f; f = e; e = d + t1;
                d = c; c = b; b = a; a = t1 + t2;
            end
            chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
            chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
        endfunction

        function void append_byte(logic [7:0] value);
            block_buf[fill] = value;
            fill++;
            if (fill == BLOCK_BYTES)
            begin
                compress();
                fill = 0;
            end
        endfunction

        // fold one accepted input beat into the hash; queue a digest on end
        function void absorb_beat(in_beat_t beat);
            logic [63:0] total;
            out_beat_t   word;
            if (beat.byte_present)
            begin
                append_byte(beat.data_byte);
                msg_bits += 64'd8;
            end
            if (!beat.end_of_message)
                return;
            total = msg_bits;
            append_byte(PAD_BYTE);
            while (fill != LENGTH_OFFSET)
                append_byte(8'h00);
            for (int i = 0; i < 8; i++)
                append_byte(total[63-8*i -: 8]);
            for (int i = 0; i < 8; i++)
            begin
                word.digest_word = chain[i];
                word.word_index  = 3'(i);
                word.last_word   = (i == 7);
                expected_words = {expected_words, word};
            end
            messages++;
            restart();
        endfunction

        function void report(string what, logic [31:0] want, logic [31:0] got);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %h actual %h", $time, what, want, got);
        endfunction

        // compare one accepted digest beat with the oldest owed word
        function void check_digest_word(out_beat_t got);
            out_beat_t want;
            if (expected_words.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected digest beat, expected none actual %h",
                             $time, got);
                return;
            end
            want = expected_words.pop_front();
            if (got.digest_word !== want.digest_word)
                report("digest_word", want.digest_word, got.digest_word);
            if (got.word_index !== want.word_index)
                report("word_index", 32'(want.word_index), 32'(got.word_index));
            if (got.last_word !== want.last_word)
                report("last_word", 32'(want.last_word), 32'(got.last_word));
            words_checked++;
        endfunction

        function int outstanding();
            return expected_words.size();
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_beat_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_beat_t out_data;

    digest_tracker tracker;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_asked;
    int beats_sent;
    int stall_count;

    sha256_byte_stream_hasher u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    function automatic in_beat_t make_beat(logic [7:0] value, logic present, logic eom);
        in_beat_t beat;
        beat.data_byte      = value;
        beat.byte_present   = present;
        beat.end_of_message = eom;
        return beat;
    endfunction

    // offer one beat, with a random gap first, and hold it until taken
    task automatic send_beat(input in_beat_t beat);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        tracker.absorb_beat(beat);
        beats_sent++;
    endtask

    // one message of random bytes with occasional ignored beats mixed in
    task automatic send_message(input int len);
        logic end_on_byte;
        end_on_byte = $urandom_range(0, 1);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_beat(make_beat(8'($urandom), 1'b0, 1'b0));
            send_beat(make_beat(8'($urandom), 1'b1, end_on_byte && (i == len - 1)));
        end
        if (!end_on_byte || len == 0)
            send_beat(make_beat(8'($urandom), 1'b0, 1'b1));
    endtask

    // mostly short messages, some around the padding edges, a few multi-block
    function automatic int pick_msg_len();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel < 13)
            return $urandom_range(0, 12);
        else if (sel < 18)
            return $urandom_range(52, 66);
        return $urandom_range(116, 130);
    endfunction

    // last message of a phase is cut short so the beat count lands near the target
    task automatic run_random(input int target);
        int len;
        while (beats_sent < target)
        begin
            len = pick_msg_len();
            if (len > target - beats_sent)
                len = target - beats_sent;
            send_message(len);
        end
    endtask

    // receiver: random back-pressure plus long holds on request
    initial
    begin
        int hold_left;
        int holds_done;
        hold_left  = 0;
        holds_done = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left == 0 && holds_done != hold_asked)
            begin
                hold_left = HOLD_CYCLES;
                holds_done++;
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // output beat checking
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            tracker.check_digest_word(out_data);
    end

    // watchdog on cycles with no beat moving
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stall_count <= 0;
        else if (stall_count >= STALL_LIMIT)
        begin
            $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
        else
            stall_count <= stall_count + 1;
    end

    // main sequence
    initial
    begin
        tracker = new;
        tracker.restart();
        beats_sent    = 0;
        send_idle_pct = 21;
        stall_count   <= 0;
        hold_asked    <= 0;
        recv_idle_pct <= 85;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_data  <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ignored beat, empty message, "abc" closed on its last byte
        send_beat(make_beat(8'hA5, 1'b0, 1'b0));
        send_beat(make_beat(8'hFF, 1'b0, 1'b1));
        send_beat(make_beat(8'h61, 1'b1, 1'b0));
        send_beat(make_beat(8'h62, 1'b1, 1'b0));
        send_beat(make_beat(8'h63, 1'b1, 1'b1));
        // single all-ones byte with end, then zero byte closed by a bare end
        send_beat(make_beat(8'hFF, 1'b1, 1'b1));
        send_beat(make_beat(8'h00, 1'b1, 1'b0));
        send_beat(make_beat(8'h5A, 1'b0, 1'b1));
        // back-to-back empty message
        send_beat(make_beat(8'h00, 1'b0, 1'b1));
        // mixed byte values with an ignored beat inside
        send_beat(make_beat(8'hFF, 1'b1, 1'b0));
        send_beat(make_beat(8'h00, 1'b1, 1'b0));
        send_beat(make_beat(8'h80, 1'b1, 1'b0));
        send_beat(make_beat(8'h7F, 1'b1, 1'b0));
        send_beat(make_beat(8'hC3, 1'b0, 1'b0));
        send_beat(make_beat(8'h01, 1'b1, 1'b1));

        // phase 1: light sender gaps, heavy receiver stalls
        run_random(beats_sent + RANDOM_ITEMS / 3);

        // phase 2: heavy sender gaps, light receiver stalls
        send_idle_pct = 85;
        recv_idle_pct <= 21;
        run_random(beats_sent + RANDOM_ITEMS / 3);

        // phase 3: full rate, opened by a long receiver hold
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        hold_asked    <= hold_asked + 1;
        run_random(beats_sent + RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
        in_valid <= 1'b0;

        // drain
        while (tracker.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("hashed %0d messages from %0d beats, %0d digest words checked",
                 tracker.messages, beats_sent, tracker.words_checked);
        $display("included empty, padding-edge and multi-block messages and a long output hold");
        if (tracker.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
